// File: rtl/drm_pkg.sv
// Damage rectangle merge table: shared request codes.
// No dependencies.
`timescale 1ns / 1ps

package drm_pkg;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_FULL  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

endpackage

// File: rtl/drm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module drm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/drm_box_unit.sv
// Shared box unit: touch test (edges inclusive) and bounding-box join of two boxes.
// No dependencies; used by the table sequencer.
`timescale 1ns / 1ps

module drm_box_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] a_left_i,
  input  logic signed [COORD_BITS-1:0] a_top_i,
  input  logic signed [COORD_BITS:0]   a_right_i,
  input  logic signed [COORD_BITS:0]   a_bottom_i,
  input  logic signed [COORD_BITS-1:0] b_left_i,
  input  logic signed [COORD_BITS-1:0] b_top_i,
  input  logic signed [COORD_BITS:0]   b_right_i,
  input  logic signed [COORD_BITS:0]   b_bottom_i,
  output logic                         touch_o,
  output logic signed [COORD_BITS-1:0] j_left_o,
  output logic signed [COORD_BITS-1:0] j_top_o,
  output logic signed [COORD_BITS:0]   j_right_o,
  output logic signed [COORD_BITS:0]   j_bottom_o
);

  localparam int C = COORD_BITS;

  logic signed [C:0] a_left_x, a_top_x, b_left_x, b_top_x;

  assign a_left_x = {a_left_i[C-1], a_left_i};
  assign a_top_x  = {a_top_i[C-1], a_top_i};
  assign b_left_x = {b_left_i[C-1], b_left_i};
  assign b_top_x  = {b_top_i[C-1], b_top_i};

  assign touch_o = (a_left_x <= b_right_i) && (b_left_x <= a_right_i) &&
                   (a_top_x <= b_bottom_i) && (b_top_x <= a_bottom_i);

  assign j_left_o   = (a_left_i < b_left_i) ? a_left_i : b_left_i;
  assign j_top_o    = (a_top_i < b_top_i) ? a_top_i : b_top_i;
  assign j_right_o  = (a_right_i > b_right_i) ? a_right_i : b_right_i;
  assign j_bottom_o = (a_bottom_i > b_bottom_i) ? a_bottom_i : b_bottom_i;

endmodule

// File: rtl/damage_rect_merge_table_top.sv
// Damage rectangle merge table: sequencer, entry RAM and overall bounds.
// Depends on drm_pkg, drm_ram and drm_box_unit.
// Mark full and clear go from idle to ST_OUT, which loads the registered result;
//   add and query scan the stored entries one RAM read a cycle, until a touch or the last one.
// One request at a time: in_stall_o stays high until the sequencer is back in idle.
// Reset: count, full flag and bounds cleared at once; entry RAM is not cleared.
`timescale 1ns / 1ps

module damage_rect_merge_table_top #(
  parameter int MAX_ENTRIES = 24,
  parameter int COORD_BITS  = 16,
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic signed [COORD_BITS-1:0] rect_x_i,
  input  logic signed [COORD_BITS-1:0] rect_y_i,
  input  logic signed [COORD_BITS-1:0] rect_width_i,
  input  logic signed [COORD_BITS-1:0] rect_height_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic                         is_full_o,
  output logic                         is_empty_o,
  output logic [CNT_W-1:0]             entry_total_o,
  output logic signed [COORD_BITS-1:0] bounds_x_o,
  output logic signed [COORD_BITS-1:0] bounds_y_o,
  output logic [COORD_BITS:0]          bounds_width_o,
  output logic [COORD_BITS:0]          bounds_height_o
);

  import drm_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int BOX_W  = 4 * C + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UNION,
    ST_APPEND,
    ST_COLLAPSE,
    ST_OUT
  } st_e;

  st_e st_q, st_d;
  req_e req_q, req_d;
  logic signed [C-1:0] r_left_q, r_left_d, r_top_q, r_top_d;
  logic signed [C:0]   r_right_q, r_right_d, r_bottom_q, r_bottom_d;
  logic signed [C-1:0] u_left_q, u_left_d, u_top_q, u_top_d;
  logic signed [C:0]   u_right_q, u_right_d, u_bottom_q, u_bottom_d;
  logic [CNT_W-1:0] count_q, count_d, idx_q, idx_d, rd_idx_q, rd_idx_d;
  logic rd_v_q, rd_v_d, full_q, full_d, hit_q, hit_d;

  logic out_valid_q, out_valid_d, out_hit_q, out_hit_d;
  logic out_full_q, out_full_d, out_empty_q, out_empty_d;
  logic [CNT_W-1:0] out_total_q, out_total_d;
  logic signed [C-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [C:0] out_w_q, out_w_d, out_h_q, out_h_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BOX_W-1:0]  ram_wdata, ram_rdata;

  logic signed [C-1:0] e_left, e_top, a_left, a_top, j_left, j_top;
  logic signed [C:0]   e_right, e_bottom, a_right, a_bottom, j_right, j_bottom;
  logic                touch;
  logic signed [C+1:0] span_w, span_h;

  drm_ram #(
    .WIDTH(BOX_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign e_left   = ram_rdata[4*C+1 -: C];
  assign e_top    = ram_rdata[3*C+1 -: C];
  assign e_right  = ram_rdata[2*C+1 -: C+1];
  assign e_bottom = ram_rdata[C:0];

  assign a_left   = (st_q == ST_SCAN) ? e_left : u_left_q;
  assign a_top    = (st_q == ST_SCAN) ? e_top : u_top_q;
  assign a_right  = (st_q == ST_SCAN) ? e_right : u_right_q;
  assign a_bottom = (st_q == ST_SCAN) ? e_bottom : u_bottom_q;

  drm_box_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_box (
    .a_left_i  (a_left),
    .a_top_i   (a_top),
    .a_right_i (a_right),
    .a_bottom_i(a_bottom),
    .b_left_i  (r_left_q),
    .b_top_i   (r_top_q),
    .b_right_i (r_right_q),
    .b_bottom_i(r_bottom_q),
    .touch_o   (touch),
    .j_left_o  (j_left),
    .j_top_o   (j_top),
    .j_right_o (j_right),
    .j_bottom_o(j_bottom)
  );

  assign span_w = {u_right_q[C], u_right_q} - {{2{u_left_q[C-1]}}, u_left_q};
  assign span_h = {u_bottom_q[C], u_bottom_q} - {{2{u_top_q[C-1]}}, u_top_q};

  assign in_stall_o = (st_q != ST_IDLE);

  always_comb begin
    st_d        = st_q;
    req_d       = req_q;
    r_left_d    = r_left_q;
    r_top_d     = r_top_q;
    r_right_d   = r_right_q;
    r_bottom_d  = r_bottom_q;
    u_left_d    = u_left_q;
    u_top_d     = u_top_q;
    u_right_d   = u_right_q;
    u_bottom_d  = u_bottom_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_idx_d    = rd_idx_q;
    rd_v_d      = rd_v_q;
    full_d      = full_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_full_d  = out_full_q;
    out_empty_d = out_empty_q;
    out_total_d = out_total_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_w_d     = out_w_q;
    out_h_d     = out_h_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = {j_left, j_top, j_right, j_bottom};
    ram_raddr   = idx_q[ADDR_W-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = req_e'(req_type_i);
          r_left_d   = rect_x_i;
          r_top_d    = rect_y_i;
          r_right_d  = {rect_x_i[C-1], rect_x_i} + {rect_width_i[C-1], rect_width_i};
          r_bottom_d = {rect_y_i[C-1], rect_y_i} + {rect_height_i[C-1], rect_height_i};
          hit_d      = 1'b0;
          idx_d      = '0;
          rd_v_d     = 1'b0;
          case (req_e'(req_type_i))
            REQ_ADD: begin
              if (full_q || rect_width_i[C-1] || (rect_width_i == '0) ||
                  rect_height_i[C-1] || (rect_height_i == '0)) begin
                st_d = ST_OUT;
              end else if (count_q == '0) begin
                st_d = ST_APPEND;
              end else begin
                st_d = ST_SCAN;
              end
            end
            REQ_FULL, REQ_CLEAR: begin
              full_d     = (req_e'(req_type_i) == REQ_FULL);
              count_d    = '0;
              u_left_d   = '0;
              u_top_d    = '0;
              u_right_d  = '0;
              u_bottom_d = '0;
              st_d       = ST_OUT;
            end
            REQ_QUERY: begin
              if (full_q) begin
                hit_d = 1'b1;
                st_d  = ST_OUT;
              end else if (count_q == '0) begin
                st_d = ST_OUT;
              end else begin
                st_d = ST_SCAN;
              end
            end
            default: st_d = ST_OUT;
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_q < count_q) begin
          idx_d    = idx_q + 1'b1;
          rd_idx_d = idx_q;
          rd_v_d   = 1'b1;
        end else begin
          rd_v_d = 1'b0;
        end
        if (rd_v_q) begin
          if (touch) begin
            rd_v_d = 1'b0;
            if (req_q == REQ_ADD) begin
              ram_we    = 1'b1;
              ram_waddr = rd_idx_q[ADDR_W-1:0];
              st_d      = ST_UNION;
            end else begin
              hit_d = 1'b1;
              st_d  = ST_OUT;
            end
          end else if (rd_idx_q == count_q - 1'b1) begin
            rd_v_d = 1'b0;
            st_d   = (req_q == REQ_ADD) ? ST_APPEND : ST_OUT;
          end
        end
      end
      ST_UNION: begin
        u_left_d   = j_left;
        u_top_d    = j_top;
        u_right_d  = j_right;
        u_bottom_d = j_bottom;
        st_d       = ST_OUT;
      end
      ST_APPEND: begin
        if (count_q == '0) begin
          u_left_d   = r_left_q;
          u_top_d    = r_top_q;
          u_right_d  = r_right_q;
          u_bottom_d = r_bottom_q;
        end else begin
          u_left_d   = j_left;
          u_top_d    = j_top;
          u_right_d  = j_right;
          u_bottom_d = j_bottom;
        end
        if (count_q < CNT_W'(MAX_ENTRIES)) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[ADDR_W-1:0];
          ram_wdata = {r_left_q, r_top_q, r_right_q, r_bottom_q};
          count_d   = count_q + 1'b1;
          st_d      = ST_OUT;
        end else begin
          count_d = CNT_W'(1);
          st_d    = ST_COLLAPSE;
        end
      end
      ST_COLLAPSE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {u_left_q, u_top_q, u_right_q, u_bottom_q};
        st_d      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_full_d  = full_q;
          out_empty_d = !full_q && (count_q == '0);
          out_total_d = count_q;
          if (count_q == '0) begin
            out_x_d = '0;
            out_y_d = '0;
            out_w_d = '0;
            out_h_d = '0;
          end else begin
            out_x_d = u_left_q;
            out_y_d = u_top_q;
            out_w_d = span_w[C:0];
            out_h_d = span_h[C:0];
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      req_q       <= REQ_ADD;
      r_left_q    <= '0;
      r_top_q     <= '0;
      r_right_q   <= '0;
      r_bottom_q  <= '0;
      u_left_q    <= '0;
      u_top_q     <= '0;
      u_right_q   <= '0;
      u_bottom_q  <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      rd_idx_q    <= '0;
      rd_v_q      <= 1'b0;
      full_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_full_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_total_q <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_w_q     <= '0;
      out_h_q     <= '0;
    end else begin
      st_q        <= st_d;
      req_q       <= req_d;
      r_left_q    <= r_left_d;
      r_top_q     <= r_top_d;
      r_right_q   <= r_right_d;
      r_bottom_q  <= r_bottom_d;
      u_left_q    <= u_left_d;
      u_top_q     <= u_top_d;
      u_right_q   <= u_right_d;
      u_bottom_q  <= u_bottom_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_idx_q    <= rd_idx_d;
      rd_v_q      <= rd_v_d;
      full_q      <= full_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      out_hit_q   <= out_hit_d;
      out_full_q  <= out_full_d;
      out_empty_q <= out_empty_d;
      out_total_q <= out_total_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_w_q     <= out_w_d;
      out_h_q     <= out_h_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign is_full_o       = out_full_q;
  assign is_empty_o      = out_empty_q;
  assign entry_total_o   = out_total_q;
  assign bounds_x_o      = out_x_q;
  assign bounds_y_o      = out_y_q;
  assign bounds_width_o  = out_w_q;
  assign bounds_height_o = out_h_q;

endmodule

// File: test/tb_damage_rect_merge_table_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for damage_rect_merge_table_top. It covers directed, collapse,
// random and back-pressure traffic, checked against an untimed model of the damage table.
// Depends on drm_pkg and the RTL top level.

module tb_damage_rect_merge_table_top;
  import drm_pkg::*;

  localparam int TABLE_DEPTH   = 24;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef logic signed [17:0] coord_t;
  typedef struct {
    coord_t left, top, right, bottom;
  } damage_box_t;
  typedef struct {
    req_e               kind;
    logic signed [15:0] x, y, w, h;
  } damage_req_t;
  typedef struct {
    logic               hit, full, empty;
    logic [4:0]         total;
    logic signed [15:0] bx, by;
    logic [16:0]        bw, bh;
  } damage_status_t;
  typedef enum int {STYLE_CLUSTER, STYLE_WIDE, STYLE_RAW} rect_style_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i    = REQ_ADD;
  logic signed [15:0] rect_x_i      = '0;
  logic signed [15:0] rect_y_i      = '0;
  logic signed [15:0] rect_width_i  = '0;
  logic signed [15:0] rect_height_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               hit_o, is_full_o, is_empty_o;
  logic [4:0]         entry_total_o;
  logic signed [15:0] bounds_x_o, bounds_y_o;
  logic [16:0]        bounds_width_o, bounds_height_o;

  // model of the damage table
  damage_box_t    tbl_entry [TABLE_DEPTH];
  int unsigned    tbl_count;
  bit             tbl_full;
  damage_box_t    tbl_union;
  damage_status_t pending_status [$];

  int send_idle_pct = 0, stall_pct = 0;
  int hold_req_cnt = 0, hold_ack_cnt = 0, hold_left = 0;
  int req_sent = 0, status_checked = 0, mismatches = 0;
  int adds_taken = 0, merges = 0, collapses = 0, queries = 0;

  damage_rect_merge_table_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .rect_x_i        (rect_x_i),
    .rect_y_i        (rect_y_i),
    .rect_width_i    (rect_width_i),
    .rect_height_i   (rect_height_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .is_full_o       (is_full_o),
    .is_empty_o      (is_empty_o),
    .entry_total_o   (entry_total_o),
    .bounds_x_o      (bounds_x_o),
    .bounds_y_o      (bounds_y_o),
    .bounds_width_o  (bounds_width_o),
    .bounds_height_o (bounds_height_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit boxes_touch(damage_box_t a, damage_box_t b);
    return a.left <= b.right && b.left <= a.right && a.top <= b.bottom && b.top <= a.bottom;
  endfunction

  function automatic damage_box_t box_join(damage_box_t a, damage_box_t b);
    damage_box_t j;
    j.left   = (a.left < b.left) ? a.left : b.left;
    j.top    = (a.top < b.top) ? a.top : b.top;
    j.right  = (a.right > b.right) ? a.right : b.right;
    j.bottom = (a.bottom > b.bottom) ? a.bottom : b.bottom;
    return j;
  endfunction

  function automatic void clear_table();
    tbl_count      = 0;
    tbl_union.left = '0;
    tbl_union.top  = '0;
    tbl_union.right  = '0;
    tbl_union.bottom = '0;
  endfunction

  // first touching entry absorbs the rectangle; no cascade into later entries
  function automatic void add_damage(damage_box_t r);
    bit merged;
    merged = 1'b0;
    adds_taken++;
    for (int i = 0; i < tbl_count && !merged; i++) begin
      if (boxes_touch(tbl_entry[i], r)) begin
        tbl_entry[i] = box_join(tbl_entry[i], r);
        merged = 1'b1;
      end
    end
    if (merged) begin
      merges++;
      tbl_union = box_join(tbl_union, r);
    end else begin
      if (tbl_count == 0) tbl_union = r;
      else tbl_union = box_join(tbl_union, r);
      if (tbl_count < TABLE_DEPTH) begin
        tbl_entry[tbl_count] = r;
        tbl_count++;
      end else begin
        tbl_entry[0] = tbl_union;
        tbl_count    = 1;
        collapses++;
      end
    end
  endfunction

  function automatic damage_status_t predict_damage(damage_req_t q);
    damage_status_t s;
    damage_box_t    r;
    r.left   = q.x;
    r.top    = q.y;
    r.right  = r.left + coord_t'(q.w);
    r.bottom = r.top + coord_t'(q.h);
    s.hit    = 1'b0;
    case (q.kind)
      REQ_ADD: if (!tbl_full && q.w > 0 && q.h > 0) add_damage(r);
      REQ_FULL: begin
        tbl_full = 1'b1;
        clear_table();
      end
      REQ_CLEAR: begin
        tbl_full = 1'b0;
        clear_table();
      end
      default: begin
        queries++;
        s.hit = tbl_full;
        for (int i = 0; i < tbl_count; i++)
          if (boxes_touch(tbl_entry[i], r)) s.hit = 1'b1;
      end
    endcase
    s.full  = tbl_full;
    s.empty = !tbl_full && tbl_count == 0;
    s.total = 5'(tbl_count);
    if (tbl_count == 0) begin
      s.bx = '0;
      s.by = '0;
      s.bw = '0;
      s.bh = '0;
    end else begin
      s.bx = tbl_union.left[15:0];
      s.by = tbl_union.top[15:0];
      s.bw = 17'(tbl_union.right - tbl_union.left);
      s.bh = 17'(tbl_union.bottom - tbl_union.top);
    end
    return s;
  endfunction

  task automatic send_req(damage_req_t q);
    bit stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= q.kind;
    rect_x_i      <= q.x;
    rect_y_i      <= q.y;
    rect_width_i  <= q.w;
    rect_height_i <= q.h;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_status = {pending_status, predict_damage(q)};
    req_sent++;
  endtask

  task automatic send_rect(req_e kind, int x, int y, int w, int h);
    damage_req_t q;
    q.kind = kind;
    q.x    = 16'(x);
    q.y    = 16'(y);
    q.w    = 16'(w);
    q.h    = 16'(h);
    send_req(q);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_in(int lo, int hi);
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic req_e pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 72) return REQ_ADD;
    if (roll < 94) return REQ_QUERY;
    if (roll < 97) return REQ_CLEAR;
    return REQ_FULL;
  endfunction

  function automatic damage_req_t make_req(req_e kind, rect_style_e style);
    damage_req_t q;
    q.kind = kind;
    case (style)
      STYLE_CLUSTER: begin
        q.x = pick_in(-300, 300);
        q.y = pick_in(-300, 300);
        q.w = pick_in(kind == REQ_QUERY ? -40 : 1, 80);
        q.h = pick_in(kind == REQ_QUERY ? -40 : 1, 80);
      end
      STYLE_WIDE: begin
        q.x = 16'($urandom);
        q.y = 16'($urandom);
        q.w = pick_in(1, 2500);
        q.h = pick_in(1, 2500);
      end
      default: begin
        q.x = 16'($urandom);
        q.y = 16'($urandom);
        q.w = 16'($urandom);
        q.h = 16'($urandom);
      end
    endcase
    if ($urandom_range(19) == 0) q.h = pick_in(-32768, 0);
    return q;
  endfunction

  function automatic void check_field(string name, logic signed [17:0] want,
                                      logic signed [17:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // result transfer is taken at the next rising edge; inputs are stable here
  always @(negedge clk_i) begin : check_status
    damage_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transfer with no request outstanding", $time);
      end else begin
        want = pending_status.pop_front();
        status_checked++;
        check_field("hit", want.hit, hit_o);
        check_field("is_full", want.full, is_full_o);
        check_field("is_empty", want.empty, is_empty_o);
        check_field("entry_total", want.total, entry_total_o);
        check_field("bounds_x", want.bx, bounds_x_o);
        check_field("bounds_y", want.by, bounds_y_o);
        check_field("bounds_width", want.bw, bounds_width_o);
        check_field("bounds_height", want.bh, bounds_height_o);
      end
    end
  end

  always @(posedge clk_i) begin : recv_stall
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_rect(REQ_QUERY, 0, 0, 10, 10);
    send_rect(REQ_ADD, 5, 5, 0, 10);
    send_rect(REQ_ADD, 5, 5, 10, 0);
    send_rect(REQ_ADD, 5, 5, -32768, 10);
    send_rect(REQ_ADD, 5, 5, 10, -1);
    send_rect(REQ_ADD, -32768, -32768, 32767, 32767);
    send_rect(REQ_ADD, 32767, 32767, 32767, 32767);
    send_rect(REQ_ADD, -1, -10000, 5, 5);
    send_rect(REQ_ADD, 100, 100, 10, 10);
    send_rect(REQ_ADD, 110, 110, 5, 5);
    send_rect(REQ_QUERY, 115, 115, 0, 0);
    send_rect(REQ_QUERY, 200, 200, -90, -90);
    send_rect(REQ_QUERY, 105, 105, -5, -5);
    send_rect(REQ_QUERY, 32767, -32768, 32767, -32768);
    send_rect(REQ_ADD, 0, 0, 32767, -32768);
    send_rect(REQ_FULL, 0, 0, 0, 0);
    send_rect(REQ_ADD, 0, 0, 10, 10);
    send_rect(REQ_QUERY, -32768, -32768, 1, 1);
    send_rect(REQ_FULL, -1, -1, -1, -1);
    send_rect(REQ_CLEAR, 0, 0, 0, 0);
    send_rect(REQ_QUERY, 0, 0, 10, 10);
    send_rect(REQ_ADD, 32767, -32768, 1, 32767);
    send_rect(REQ_CLEAR, -1, -1, -1, -1);
    drain_results();
  endtask

  // fill all entries with disjoint boxes, overflow into one, then merge without cascade
  task automatic test_collapse();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_rect(REQ_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < TABLE_DEPTH; i++) send_rect(REQ_ADD, i * 200 - 2400, 500, 50, 50);
    send_rect(REQ_QUERY, -2300, 520, 20, 20);
    send_rect(REQ_ADD, 10000, 10000, 10, 10);
    send_rect(REQ_QUERY, -2300, 520, 20, 20);
    send_rect(REQ_CLEAR, 0, 0, 0, 0);
    send_rect(REQ_ADD, 0, 0, 10, 10);
    send_rect(REQ_ADD, 20, 0, 10, 10);
    send_rect(REQ_ADD, 8, 0, 14, 5);
    send_rect(REQ_QUERY, 25, 12, 1, 1);
    drain_results();
  endtask

  task automatic test_random_phase(int idle_send, int idle_recv, int n_items);
    int          stop_at;
    int          burst;
    rect_style_e style;
    send_idle_pct = idle_send;
    stall_pct     = idle_recv;
    stop_at       = req_sent + n_items;
    while (req_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: style = STYLE_CLUSTER;
        5, 6, 7:       style = STYLE_WIDE;
        default:       style = STYLE_RAW;
      endcase
      burst = $urandom_range(45, 5);
      send_req(make_req(REQ_CLEAR, style));
      repeat (burst) send_req(make_req(pick_kind(), style));
    end
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering, so the input side backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req_cnt++;
    repeat (30) send_req(make_req(pick_kind(), STYLE_WIDE));
    drain_results();
  endtask

  initial begin
    clear_table();
    tbl_full = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_collapse();
    test_random_phase(0, 0, 260);
    test_random_phase(70, 0, 260);
    test_random_phase(0, 70, 260);
    test_random_phase(12, 12, 260);
    test_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: %0d adds taken, %0d merged, %0d table collapses, %0d queries.",
             req_sent, adds_taken, merges, collapses, queries);
    $display("%0d results compared over four idle mixes and one long receiver hold-off.",
             status_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
